### rtl/core/bgtr_pkg.sv
// Shared constants, types and codes for the bitmap glyph text renderer.
package bgtr_pkg;

  // Store sizes
  localparam int BITMAP_BYTES    = 8192;
  localparam int GLYPH_CODES     = 256;
  localparam int MAX_GLYPH_BYTES = 64;

  localparam int METRIC_DEPTH = GLYPH_CODES + 1;
  localparam int MIDX_W       = $clog2(METRIC_DEPTH);
  localparam int BADDR_W      = $clog2(BITMAP_BYTES);
  localparam int OFFS_W       = 14;
  localparam int SADDR_W      = OFFS_W + 1;
  localparam int CNT_W        = $clog2(MAX_GLYPH_BYTES + 1);
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  // Character codes and spacing
  localparam logic [7:0] CODE_SPACE  = 8'd32;
  localparam logic [7:0] CODE_N      = 8'd110;
  localparam logic [8:0] ADV_EXTRA   = 9'd3;
  localparam logic [15:0] LEAD_IN    = 16'd2;

  // Input operation codes
  localparam logic [1:0] OP_LOAD_METRIC = 2'd0;
  localparam logic [1:0] OP_LOAD_BITMAP = 2'd1;
  localparam logic [1:0] OP_SET_CURSOR  = 2'd2;
  localparam logic [1:0] OP_DRAW_CHAR   = 2'd3;

  // Configuration register indexes
  localparam logic CFG_ITALIC_SLANT = 1'b0;
  localparam logic CFG_INK_COLOR    = 1'b1;

  // Command kinds passed from front to back
  typedef enum logic [2:0] {
    K_METRIC,
    K_BITMAP,
    K_CURSOR,
    K_DRAW_SPACE,
    K_DRAW_GLYPH,
    K_DRAW_EMPTY
  } kind_t;

  typedef struct packed {
    logic [OFFS_W-1:0] offset;
    logic [7:0]        rise;
    logic [7:0]        width;
  } metric_t;

  typedef struct packed {
    kind_t             kind;
    logic [MIDX_W-1:0] midx;
    metric_t           metric;
    logic [12:0]       baddr;
    logic [7:0]        bval;
    logic [15:0]       x;
    logic [15:0]       y;
    logic [7:0]        code;
  } cmd_t;

endpackage

### rtl/core/bgtr_in_if.sv
// Input channel of the glyph renderer: valid/ready plus item fields.
interface bgtr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [8:0]  metric_index;
  logic [13:0] metric_offset;
  logic [7:0]  metric_rise;
  logic [7:0]  metric_width;
  logic [12:0] bitmap_address;
  logic [7:0]  bitmap_value;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [7:0]  char_code;

  modport source (
    output valid, op, metric_index, metric_offset, metric_rise, metric_width,
           bitmap_address, bitmap_value, pos_x, pos_y, char_code,
    input  ready
  );
  modport sink (
    input  valid, op, metric_index, metric_offset, metric_rise, metric_width,
           bitmap_address, bitmap_value, pos_x, pos_y, char_code,
    output ready
  );
endinterface

### rtl/core/bgtr_out_if.sv
// Result channel of the glyph renderer: valid/ready plus span fields.
interface bgtr_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] span_x;
  logic signed [15:0] span_y;
  logic [7:0]  pixel_mask;
  logic [7:0]  span_color;
  logic [8:0]  char_advance;
  logic        final_span;

  modport source (
    output valid, span_x, span_y, pixel_mask, span_color, char_advance, final_span,
    input  ready
  );
  modport sink (
    input  valid, span_x, span_y, pixel_mask, span_color, char_advance, final_span,
    output ready
  );
endinterface

### rtl/core/bgtr_ram.sv
// Generic single-port RAM with registered read.
module bgtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;
endmodule

### rtl/core/bgtr_front.sv
// Front end: accepts input beats, classifies them and builds queue commands.
module bgtr_front (
  bgtr_in_if.sink          in_chan,
  input  logic             q_full,
  output logic             q_push,
  output bgtr_pkg::cmd_t   q_cmd
);
  logic drop;

  // Decode the operation into a command kind; out-of-range loads are dropped
  always_comb begin
    q_cmd        = '0;
    drop         = 1'b0;
    q_cmd.midx   = in_chan.metric_index;
    q_cmd.metric = '{offset: in_chan.metric_offset, rise: in_chan.metric_rise,
                     width: in_chan.metric_width};
    q_cmd.baddr  = in_chan.bitmap_address;
    q_cmd.bval   = in_chan.bitmap_value;
    q_cmd.x      = in_chan.pos_x;
    q_cmd.y      = in_chan.pos_y;
    q_cmd.code   = in_chan.char_code;
    q_cmd.kind   = bgtr_pkg::K_CURSOR;
    unique case (in_chan.op)
      bgtr_pkg::OP_LOAD_METRIC: begin
        q_cmd.kind = bgtr_pkg::K_METRIC;
        drop = (32'(in_chan.metric_index) > bgtr_pkg::GLYPH_CODES);
      end
      bgtr_pkg::OP_LOAD_BITMAP: begin
        q_cmd.kind = bgtr_pkg::K_BITMAP;
        drop = (32'(in_chan.bitmap_address) >= bgtr_pkg::BITMAP_BYTES);
      end
      bgtr_pkg::OP_SET_CURSOR: begin
        q_cmd.kind = bgtr_pkg::K_CURSOR;
      end
      bgtr_pkg::OP_DRAW_CHAR: begin
        priority if (in_chan.char_code == bgtr_pkg::CODE_SPACE) begin
          q_cmd.kind = bgtr_pkg::K_DRAW_SPACE;
        end else if (32'(in_chan.char_code) >= bgtr_pkg::GLYPH_CODES) begin
          q_cmd.kind = bgtr_pkg::K_DRAW_EMPTY;
        end else begin
          q_cmd.kind = bgtr_pkg::K_DRAW_GLYPH;
        end
      end
      default: begin
        q_cmd.kind = bgtr_pkg::K_CURSOR;
      end
    endcase
  end

  assign in_chan.ready = !q_full;
  assign q_push        = in_chan.valid && !q_full && !drop;
endmodule

### rtl/core/bgtr_cmd_queue.sv
// Short command queue between front end and back end.
module bgtr_cmd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bgtr_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output bgtr_pkg::cmd_t  head_cmd
);
  bgtr_pkg::cmd_t              slot_r [bgtr_pkg::QDEPTH];
  logic [bgtr_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [bgtr_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [bgtr_pkg::QCNT_W-1:0] count_r;
  logic                        do_pop;

  assign full       = (count_r == bgtr_pkg::QCNT_W'(bgtr_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      priority if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !push) begin
        count_r <= count_r - 1'b1;
      end else begin
        count_r <= count_r;
      end
    end
  end
endmodule

### rtl/core/bgtr_back.sv
// Back end: executes commands, walks glyph bitmaps and emits spans.
module bgtr_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  bgtr_pkg::cmd_t  q_cmd,
  output logic            q_pop,
  input  logic            italic_slant,
  input  logic [7:0]      ink_color,
  bgtr_out_if.source      out_chan
);
  typedef enum logic [2:0] {
    S_IDLE,
    S_META0,
    S_META1,
    S_EMIT_ONE,
    S_SPAN
  } state_t;

  state_t                      state_r;
  logic [15:0]                 pen_x_r, pen_y_r;
  logic [7:0]                  code_r;
  logic                        space_r;
  logic [bgtr_pkg::OFFS_W-1:0] base_r;
  logic [7:0]                  rise_r;
  logic [5:0]                  bpr_r;
  logic [8:0]                  adv_r;
  logic [bgtr_pkg::CNT_W-1:0]  count_r, idx_r;
  logic [4:0]                  col_r;
  logic [5:0]                  row_r;

  // Read stage and output register
  logic        b_valid_r, b_zero_r, b_last_r;
  logic [15:0] b_x_r, b_y_r;
  logic [8:0]  b_adv_r;
  logic        o_valid_r, o_last_r;
  logic [15:0] o_x_r, o_y_r;
  logic [7:0]  o_mask_r, o_color_r;
  logic [8:0]  o_adv_r;

  logic                          advance, issue, last_span;
  bgtr_pkg::metric_t             m_rd;
  logic [bgtr_pkg::MIDX_W-1:0]   m_addr;
  logic                          m_we;
  logic [7:0]                    bmp_rd;
  logic [bgtr_pkg::BADDR_W-1:0]  bmp_addr;
  logic                          bmp_we;
  logic [bgtr_pkg::SADDR_W-1:0]  span_addr;
  logic                          span_out;
  logic [8:0]                    dy, dy_bias, half;
  logic [15:0]                   span_x, span_y;
  logic [bgtr_pkg::SADDR_W-1:0]  nb;
  logic [bgtr_pkg::CNT_W-1:0]    nb_cnt;
  logic [8:0]                    w_plus7;

  assign advance   = !o_valid_r || out_chan.ready;
  assign issue     = advance && (state_r == S_SPAN || state_r == S_EMIT_ONE);
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign last_span = (idx_r == count_r - 1'b1);

  // Store write strobes come straight from the popped command
  assign m_we   = q_pop && (q_cmd.kind == bgtr_pkg::K_METRIC);
  assign bmp_we = q_pop && (q_cmd.kind == bgtr_pkg::K_BITMAP);

  // Metric port address
  always_comb begin
    m_addr = q_cmd.midx;
    if (state_r == S_META0) begin
      m_addr = {1'b0, code_r} + 1'b1;
    end else if (q_cmd.kind == bgtr_pkg::K_DRAW_SPACE) begin
      m_addr = {1'b0, bgtr_pkg::CODE_N};
    end else if (q_cmd.kind != bgtr_pkg::K_METRIC) begin
      m_addr = {1'b0, q_cmd.code};
    end
  end

  // Span address and position
  assign span_addr = {1'b0, base_r} + bgtr_pkg::SADDR_W'(idx_r);
  assign span_out  = (32'(span_addr) >= bgtr_pkg::BITMAP_BYTES);
  assign bmp_addr  = bmp_we ? q_cmd.baddr : span_addr[bgtr_pkg::BADDR_W-1:0];
  assign dy        = {3'b000, row_r} - {1'b0, rise_r};
  // Halve toward zero
  assign dy_bias   = dy + {8'd0, dy[8]};
  assign half      = italic_slant ? {dy_bias[8], dy_bias[8:1]} : 9'd0;
  assign span_x    = pen_x_r + bgtr_pkg::LEAD_IN + {8'd0, col_r, 3'b000}
                     - {{7{half[8]}}, half};
  assign span_y    = pen_y_r + {{7{dy[8]}}, dy};

  // Byte count of the glyph, clipped
  assign nb = {1'b0, m_rd.offset} - {1'b0, base_r};
  always_comb begin
    priority if (bpr_r == '0 || nb[bgtr_pkg::SADDR_W-1]) begin
      nb_cnt = '0;
    end else if (32'(nb) > bgtr_pkg::MAX_GLYPH_BYTES) begin
      nb_cnt = bgtr_pkg::CNT_W'(bgtr_pkg::MAX_GLYPH_BYTES);
    end else begin
      nb_cnt = nb[bgtr_pkg::CNT_W-1:0];
    end
  end
  assign w_plus7 = {1'b0, m_rd.width} + 9'd7;

  bgtr_ram #(.WIDTH($bits(bgtr_pkg::metric_t)), .DEPTH(bgtr_pkg::METRIC_DEPTH))
    u_metric_ram (
      .clk  (clk),
      .we   (m_we),
      .re   (1'b1),
      .addr (m_addr),
      .wdata(q_cmd.metric),
      .rdata(m_rd)
    );

  bgtr_ram #(.WIDTH(8), .DEPTH(bgtr_pkg::BITMAP_BYTES)) u_bitmap_ram (
    .clk  (clk),
    .we   (bmp_we),
    .re   (issue && state_r == S_SPAN),
    .addr (bmp_addr),
    .wdata(q_cmd.bval),
    .rdata(bmp_rd)
  );

  // Sequencer, pen and span pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pen_x_r   <= '0;
      pen_y_r   <= '0;
      b_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            code_r  <= q_cmd.code;
            space_r <= (q_cmd.kind == bgtr_pkg::K_DRAW_SPACE);
            unique case (q_cmd.kind)
              bgtr_pkg::K_CURSOR: begin
                pen_x_r <= q_cmd.x;
                pen_y_r <= q_cmd.y;
              end
              bgtr_pkg::K_DRAW_SPACE, bgtr_pkg::K_DRAW_GLYPH: begin
                state_r <= S_META0;
              end
              bgtr_pkg::K_DRAW_EMPTY: begin
                adv_r   <= bgtr_pkg::ADV_EXTRA;
                state_r <= S_EMIT_ONE;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_META0: begin
          adv_r  <= {1'b0, m_rd.width} + bgtr_pkg::ADV_EXTRA;
          base_r <= m_rd.offset;
          rise_r <= m_rd.rise;
          bpr_r  <= w_plus7[8:3];
          state_r <= space_r ? S_EMIT_ONE : S_META1;
        end
        S_META1: begin
          count_r <= nb_cnt;
          idx_r   <= '0;
          col_r   <= '0;
          row_r   <= '0;
          state_r <= (nb_cnt == '0) ? S_EMIT_ONE : S_SPAN;
        end
        S_EMIT_ONE: begin
          if (advance) begin
            pen_x_r <= pen_x_r + {7'd0, adv_r};
            state_r <= S_IDLE;
          end
        end
        S_SPAN: begin
          if (advance) begin
            idx_r <= idx_r + 1'b1;
            if (col_r == 5'(bpr_r - 1'b1)) begin
              col_r <= '0;
              row_r <= row_r + 1'b1;
            end else begin
              col_r <= col_r + 1'b1;
            end
            if (last_span) begin
              pen_x_r <= pen_x_r + {7'd0, adv_r};
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (advance) begin
        b_valid_r <= issue;
        o_valid_r <= b_valid_r;
      end
    end
  end

  // Payload stages, advanced together with the valid bits
  always_ff @(posedge clk) begin
    if (advance) begin
      if (state_r == S_SPAN) begin
        b_x_r    <= span_x;
        b_y_r    <= span_y;
        b_zero_r <= span_out;
        b_last_r <= last_span;
      end else begin
        b_x_r    <= pen_x_r;
        b_y_r    <= pen_y_r;
        b_zero_r <= 1'b1;
        b_last_r <= 1'b1;
      end
      b_adv_r   <= adv_r;
      o_x_r     <= b_x_r;
      o_y_r     <= b_y_r;
      o_mask_r  <= b_zero_r ? 8'd0 : bmp_rd;
      o_color_r <= ink_color;
      o_adv_r   <= b_adv_r;
      o_last_r  <= b_last_r;
    end
  end

  assign out_chan.valid        = o_valid_r;
  assign out_chan.span_x       = o_x_r;
  assign out_chan.span_y       = o_y_r;
  assign out_chan.pixel_mask   = o_mask_r;
  assign out_chan.span_color   = o_color_r;
  assign out_chan.char_advance = o_adv_r;
  assign out_chan.final_span   = o_last_r;
endmodule

### rtl/core/bitmap_glyph_text_renderer_unit.sv
// Top level of the bitmap glyph text renderer.
//
// in_chan takes one beat per item: load metric, load bitmap byte, set cursor
// or draw character. Loads and cursor moves produce no result. A draw
// produces one span beat per stored glyph byte (up to 64) on out_chan, each
// an 8-pixel mask at (span_x, span_y) with the ink color; final_span marks
// the last beat of the character. A space, an empty glyph or a glyph with no
// bytes gives one beat with a zero mask at the pen position.
// A front end decodes beats into a 4-entry command queue; the back end runs
// them in order. Loads and cursor moves are done when the back end pops them.
// A draw reads the glyph's metric entry and the next one, works out the byte
// count, then walks its bytes. The single-port bitmap memory paces spans at
// one per cycle while the receiver does not stall.
// When the receiver stalls, the span pipeline freezes, the sequencer waits in
// its span and emit states, and the queue fills until in_chan.ready drops.
// Reset clears the pen to (0, 0), slant to off, ink color to 255 and empties
// the queue; glyph stores are not cleared and must be loaded before use.
// Config must be written only while idle; the block does not enforce it.
module bitmap_glyph_text_renderer_unit (
  input  logic        clk,
  input  logic        rst_n,
  bgtr_in_if.sink     in_chan,
  bgtr_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  logic           italic_slant_r;
  logic [7:0]     ink_color_r;
  logic           q_push, q_full, q_pop, q_valid;
  bgtr_pkg::cmd_t push_cmd, head_cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      italic_slant_r <= 1'b0;
      ink_color_r    <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bgtr_pkg::CFG_ITALIC_SLANT: italic_slant_r <= cfg_data[0];
        bgtr_pkg::CFG_INK_COLOR:    ink_color_r    <= cfg_data;
        default:                    ink_color_r    <= ink_color_r;
      endcase
    end
  end

  bgtr_front u_front (
    .in_chan(in_chan),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  bgtr_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_cmd  (head_cmd)
  );

  bgtr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_cmd       (head_cmd),
    .q_pop       (q_pop),
    .italic_slant(italic_slant_r),
    .ink_color   (ink_color_r),
    .out_chan    (out_chan)
  );
endmodule

### dv/bgtr_span_checker.sv
// Span checker for the glyph renderer: tracks font, pen and config, predicts and compares spans.
`timescale 1ns / 1ps

module bgtr_span_checker
  import bgtr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  bgtr_in_if         in_mon,
  bgtr_out_if        out_mon,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  output int         error_count,
  output int         spans_owed
);

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  mask;
    logic [7:0]  color;
    logic [8:0]  adv;
    logic        last;
  } span_t;

  // Predicted font tables, pen and settings
  logic [13:0] offs_tab [0:GLYPH_CODES];
  logic [7:0]  rise_tab [0:GLYPH_CODES];
  logic [7:0]  wid_tab  [0:GLYPH_CODES];
  logic [7:0]  glyph_mem [0:BITMAP_BYTES-1];
  logic [15:0] pen_x;
  logic [15:0] pen_y;
  logic        slant;
  logic [7:0]  ink;

  span_t expected_spans[$];
  int    mismatches = 0;
  int    span_beats = 0;

  // Works out the spans of one character and moves the pen on
  task automatic render_char(input logic [7:0] code);
    int          width;
    int          rise;
    int          nbytes;
    int          bpr;
    int          addr;
    int          col;
    int          dy;
    int          shear;
    int          i;
    logic [13:0] base;
    logic [8:0]  adv;
    span_t       s;
    width  = 0;
    rise   = 0;
    nbytes = 0;
    bpr    = 0;
    base   = '0;
    if (code == CODE_SPACE) begin
      adv = 9'(wid_tab[CODE_N]) + ADV_EXTRA;
    end else begin
      width  = int'(wid_tab[code]);
      base   = offs_tab[code];
      rise   = int'(rise_tab[code]);
      nbytes = int'(offs_tab[int'(code) + 1]) - int'(base);
      adv    = 9'(width) + ADV_EXTRA;
      bpr    = (width + 7) / 8;
      if (bpr == 0 || nbytes < 0) nbytes = 0;
      if (nbytes > MAX_GLYPH_BYTES) nbytes = MAX_GLYPH_BYTES;
    end
    for (i = 0; i < nbytes; i++) begin
      addr    = int'(base) + i;
      col     = (i % bpr) * 8;
      dy      = i / bpr - rise;
      // shear truncates toward zero, same as integer division here
      shear   = (slant ? dy : 0) / 2;
      s.x     = pen_x + LEAD_IN + 16'(col) - 16'(shear);
      s.y     = pen_y + 16'(dy);
      s.mask  = (addr < BITMAP_BYTES) ? glyph_mem[addr] : 8'd0;
      s.color = ink;
      s.adv   = adv;
      s.last  = (i == nbytes - 1);
      expected_spans.push_back(s);
    end
    // nothing to draw still gives one blank beat at the pen
    if (nbytes == 0) begin
      s.x     = pen_x;
      s.y     = pen_y;
      s.mask  = 8'd0;
      s.color = ink;
      s.adv   = adv;
      s.last  = 1'b1;
      expected_spans.push_back(s);
    end
    pen_x = pen_x + 16'(adv);
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("span beat %0d, %s: expected %0d, got %0d", span_beats, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    span_t exp_span;
    if (!rst_n) begin
      pen_x = '0;
      pen_y = '0;
      slant = 1'b0;
      ink   = 8'd255;
      expected_spans.delete();
    end else begin
      // result beat against the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        if (expected_spans.size() == 0) begin
          $error("span beat %0d arrived with no span expected", span_beats);
          mismatches++;
        end else begin
          exp_span = expected_spans.pop_front();
          compare_field("span_x", int'($signed(exp_span.x)), int'(out_mon.span_x));
          compare_field("span_y", int'($signed(exp_span.y)), int'(out_mon.span_y));
          compare_field("pixel_mask", int'(exp_span.mask), int'(out_mon.pixel_mask));
          compare_field("span_color", int'(exp_span.color), int'(out_mon.span_color));
          compare_field("char_advance", int'(exp_span.adv), int'(out_mon.char_advance));
          compare_field("final_span", int'(exp_span.last), int'(out_mon.final_span));
        end
        span_beats++;
      end
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_ITALIC_SLANT: slant = cfg_data[0];
          CFG_INK_COLOR:    ink   = cfg_data;
          default: ;
        endcase
      end
      // command beat
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.op)
          OP_LOAD_METRIC: begin
            if (in_mon.metric_index <= GLYPH_CODES) begin
              offs_tab[in_mon.metric_index] = in_mon.metric_offset;
              rise_tab[in_mon.metric_index] = in_mon.metric_rise;
              wid_tab[in_mon.metric_index]  = in_mon.metric_width;
            end
          end
          OP_LOAD_BITMAP: glyph_mem[in_mon.bitmap_address] = in_mon.bitmap_value;
          OP_SET_CURSOR: begin
            pen_x = in_mon.pos_x;
            pen_y = in_mon.pos_y;
          end
          OP_DRAW_CHAR: render_char(in_mon.char_code);
          default: ;
        endcase
      end
    end
    spans_owed  <= expected_spans.size();
    error_count <= mismatches;
  end

endmodule

### dv/bitmap_glyph_text_renderer_unit_test.sv
// Testbench top for the glyph renderer: clock, reset, font and text stimulus, verdict.
`timescale 1ns / 1ps

module bitmap_glyph_text_renderer_unit_test;
  import bgtr_pkg::*;

  localparam int BEATS_PER_PHASE = 70;
  localparam int SETTLE_CYCLES   = 24;
  localparam int DRAIN_CYCLES    = 40;
  localparam int STALL_LIMIT     = 3000;
  localparam int HOLD_AT_BEAT    = 60;
  localparam int HOLD_CYCLES     = 400;

  typedef struct {
    logic [1:0]  op;
    logic [8:0]  midx;
    logic [13:0] moff;
    logic [7:0]  mrise;
    logic [7:0]  mwid;
    logic [12:0] baddr;
    logic [7:0]  bval;
    logic [15:0] px;
    logic [15:0] py;
    logic [7:0]  code;
  } beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;
  int         fail_count;
  int         spans_owed;

  bgtr_in_if  in_chan();
  bgtr_out_if out_chan();

  bitmap_glyph_text_renderer_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bgtr_span_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .error_count (fail_count),
    .spans_owed  (spans_owed)
  );

  always #10 clk = ~clk;

  // Font as loaded so far, so draws never touch unwritten entries
  logic [13:0] font_off [0:GLYPH_CODES];
  logic [7:0]  font_wid [0:GLYPH_CODES];
  bit          font_set [0:GLYPH_CODES];
  bit          byte_set [0:BITMAP_BYTES-1];
  logic [7:0]  recent_code = CODE_N;
  int          burst_left = 0;
  int          beats_sent = 0;
  int          in_beats = 0;
  int          idle_cycles = 0;

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) in_beats <= in_beats + 1;
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Result side: stall modes that change now and then, plus one long hold
  initial begin
    int  mode;
    int  mode_left;
    int  hold_left;
    int  tick;
    bit  hold_done;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    hold_done = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (!rst_n) begin
        out_chan.ready = 1'b0;
      end else if (hold_left > 0) begin
        out_chan.ready = 1'b0;
        hold_left--;
      end else if (!hold_done && in_beats >= HOLD_AT_BEAT) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES - 1;
        out_chan.ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 200);
        end
        mode_left--;
        case (mode)
          0:       out_chan.ready = 1'b1;
          1:       out_chan.ready = 1'($urandom_range(0, 1));
          2:       out_chan.ready = ($urandom_range(0, 3) == 0);
          default: out_chan.ready = (tick % 3 != 0);
        endcase
      end
    end
  end

  function automatic beat_t random_beat();
    beat_t b;
    b.op    = OP_DRAW_CHAR;
    b.midx  = 9'($urandom);
    b.moff  = 14'($urandom);
    b.mrise = 8'($urandom);
    b.mwid  = 8'($urandom);
    b.baddr = 13'($urandom);
    b.bval  = 8'($urandom);
    b.px    = 16'($urandom);
    b.py    = 16'($urandom);
    b.code  = 8'($urandom);
    return b;
  endfunction

  // One beat on the command channel; sender runs in bursts with gaps
  task automatic put_beat(input beat_t b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 16) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_chan.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_chan.op             = b.op;
    in_chan.metric_index   = b.midx;
    in_chan.metric_offset  = b.moff;
    in_chan.metric_rise    = b.mrise;
    in_chan.metric_width   = b.mwid;
    in_chan.bitmap_address = b.baddr;
    in_chan.bitmap_value   = b.bval;
    in_chan.pos_x          = b.px;
    in_chan.pos_y          = b.py;
    in_chan.char_code      = b.code;
    in_chan.valid          = 1'b1;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    beats_sent++;
  endtask

  task automatic load_metric(input int idx, input int off, input int rise, input int wid);
    beat_t b;
    b       = random_beat();
    b.op    = OP_LOAD_METRIC;
    b.midx  = 9'(idx);
    b.moff  = 14'(off);
    b.mrise = 8'(rise);
    b.mwid  = 8'(wid);
    if (idx <= GLYPH_CODES) begin
      font_set[idx] = 1;
      font_off[idx] = 14'(off);
      font_wid[idx] = 8'(wid);
    end
    put_beat(b);
  endtask

  task automatic load_byte(input int addr, input int value);
    beat_t b;
    b       = random_beat();
    b.op    = OP_LOAD_BITMAP;
    b.baddr = 13'(addr);
    b.bval  = 8'(value);
    byte_set[b.baddr] = 1;
    put_beat(b);
  endtask

  task automatic move_pen(input int x, input int y);
    beat_t b;
    b    = random_beat();
    b.op = OP_SET_CURSOR;
    b.px = 16'(x);
    b.py = 16'(y);
    put_beat(b);
  endtask

  task automatic draw_char(input logic [7:0] code);
    beat_t b;
    b      = random_beat();
    b.op   = OP_DRAW_CHAR;
    b.code = code;
    put_beat(b);
  endtask

  // True when drawing this code reads only loaded metrics and bytes
  function automatic bit drawable(input logic [7:0] code);
    int n;
    int i;
    if (code == CODE_SPACE) return font_set[CODE_N];
    if (!font_set[code] || !font_set[int'(code) + 1]) return 0;
    n = int'(font_off[int'(code) + 1]) - int'(font_off[code]);
    if (font_wid[code] == 0 || n < 0) n = 0;
    if (n > MAX_GLYPH_BYTES) n = MAX_GLYPH_BYTES;
    for (i = 0; i < n; i++) begin
      if (int'(font_off[code]) + i < BITMAP_BYTES && !byte_set[int'(font_off[code]) + i]) return 0;
    end
    return 1;
  endfunction

  function automatic int pick_rise();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 10);
  endfunction

  // Glyph metric, the next entry that closes it, and its bitmap bytes
  task automatic define_random_glyph();
    int         wid;
    int         bpr;
    int         n;
    int         off;
    int         nxt;
    int         i;
    logic [7:0] code;
    code = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0:       wid = 0;
      1:       wid = $urandom_range(17, 255);
      default: wid = $urandom_range(1, 16);
    endcase
    bpr = (wid + 7) / 8;
    n   = ((bpr == 0) ? 1 : bpr) * $urandom_range(1, 6);
    if ($urandom_range(0, 19) == 0) n = -int'($urandom_range(1, 20));
    off = ($urandom_range(0, 9) == 0) ? $urandom_range(8100, 16383) : $urandom_range(0, 8191);
    nxt = off + n;
    if (nxt < 0) nxt = 0;
    if (nxt > 16383) nxt = 16383;
    load_metric(code, off, pick_rise(), wid);
    load_metric(int'(code) + 1, nxt, pick_rise(), $urandom_range(0, 16));
    if (wid != 0) begin
      for (i = 0; i < nxt - off && i < MAX_GLYPH_BYTES; i++) begin
        if (off + i < BITMAP_BYTES) load_byte(off + i, $urandom_range(0, 255));
      end
    end
    recent_code = code;
  endtask

  // A short run of text, partly the glyph just defined
  task automatic draw_run();
    int         run;
    int         tries;
    logic [7:0] code;
    if ($urandom_range(0, 3) == 0) move_pen($urandom, $urandom);
    run = $urandom_range(1, 6);
    repeat (run) begin
      tries = 0;
      do begin
        case ($urandom_range(0, 5))
          0:       code = CODE_SPACE;
          1, 2:    code = recent_code;
          default: code = 8'($urandom_range(0, 255));
        endcase
        tries++;
      end while (!drawable(code) && tries < 16);
      if (drawable(code)) draw_char(code);
    end
  endtask

  // Stop sending and wait until every span has come and the queue has drained
  task automatic wait_idle(input int cycles);
    in_chan.valid = 1'b0;
    burst_left = 0;
    while (spans_owed != 0) @(posedge clk);
    repeat (cycles) @(negedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [7:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  initial begin
    int phase;
    int phase_end;
    int pick;
    in_chan.valid          = 1'b0;
    in_chan.op             = OP_LOAD_METRIC;
    in_chan.metric_index   = '0;
    in_chan.metric_offset  = '0;
    in_chan.metric_rise    = '0;
    in_chan.metric_width   = '0;
    in_chan.bitmap_address = '0;
    in_chan.bitmap_value   = '0;
    in_chan.pos_x          = '0;
    in_chan.pos_y          = '0;
    in_chan.char_code      = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_ITALIC_SLANT;
    cfg_data  = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: upright, full ink
    write_cfg(CFG_ITALIC_SLANT, 8'd0);
    write_cfg(CFG_INK_COLOR, 8'd255);
    load_metric(CODE_N, 0, 3, 6);
    load_metric(int'(CODE_N) + 1, 4, 2, 5);
    load_byte(0, 8'h00);
    load_byte(1, 8'hFF);
    load_byte(2, 8'h01);
    load_byte(3, 8'h80);
    draw_char(CODE_N);
    draw_char(CODE_SPACE);
    // pen wraps at the edges
    move_pen(-32768, 32767);
    draw_char(CODE_N);
    // widest, tallest glyph, longer than the cap and running off the store
    load_metric(0, 8188, 255, 255);
    load_metric(1, 8188 + 80, 4, 7);
    load_byte(8188, 8'hA5);
    load_byte(8189, 8'h5A);
    load_byte(8190, 8'hFF);
    load_byte(8191, 8'h00);
    draw_char(8'd0);
    // zero width, closed by the extra metric entry
    load_metric(255, 100, 0, 0);
    load_metric(GLYPH_CODES, 200, 9, 9);
    draw_char(8'd255);
    // next offset below its own
    load_metric(2, 300, 5, 8);
    load_metric(3, 200, 0, 3);
    draw_char(8'd2);
    // index past the table is dropped
    load_metric(511, 16383, 255, 255);
    move_pen(32767, -32768);
    draw_char(CODE_N);

    // Random phases, each under its own settings
    for (phase = 0; phase < 4; phase++) begin
      wait_idle(SETTLE_CYCLES);
      case (phase)
        0: begin
          write_cfg(CFG_ITALIC_SLANT, 8'd1);
          write_cfg(CFG_INK_COLOR, 8'd0);
        end
        1: begin
          write_cfg(CFG_ITALIC_SLANT, 8'd0);
          write_cfg(CFG_INK_COLOR, 8'($urandom_range(0, 255)));
        end
        2: begin
          write_cfg(CFG_ITALIC_SLANT, 8'd1);
          write_cfg(CFG_INK_COLOR, 8'($urandom_range(0, 255)));
        end
        default: begin
          write_cfg(CFG_ITALIC_SLANT, 8'($urandom_range(0, 1)));
          write_cfg(CFG_INK_COLOR, 8'd255);
        end
      endcase
      phase_end = beats_sent + BEATS_PER_PHASE;
      while (beats_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          define_random_glyph();
        end else if (pick < 75) begin
          draw_run();
        end else if (pick < 85) begin
          move_pen($urandom, $urandom);
        end else if (pick < 92) begin
          load_metric($urandom_range(GLYPH_CODES + 1, 511), $urandom_range(0, 16383),
                      $urandom_range(0, 255), $urandom_range(0, 255));
        end else begin
          load_byte($urandom_range(0, BITMAP_BYTES - 1), $urandom_range(0, 255));
        end
      end
    end

    wait_idle(DRAIN_CYCLES);
    if (fail_count == 0 && spans_owed == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
